// ===== src/priority_task_scheduler_macros.svh =====
// assertion macros for the priority task scheduler
`ifndef PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define PTS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define PTS_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PTS_ASSERT(label, clk, rst_n, prop, msg)
`define PTS_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== src/pts_pkg.sv =====
// shared types and constants of the priority task scheduler
package pts_pkg;

	localparam int NUM_TASKS  = 32;
	localparam int DELAY_BITS = 16;

	localparam int TASK_W     = 5;
	localparam int STEP_W     = 10;
	localparam int TICKS_W    = 16;
	localparam int MAP_W      = 32;
	localparam int STEP_RESET = 1;

	localparam int IDX_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam int CMP_W = (DELAY_BITS > STEP_W) ? DELAY_BITS : STEP_W;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READY = 2'd1,
		MODE_DELAY = 2'd2,
		MODE_SCHED = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic [TASK_W-1:0]   task_index;
		logic [TICKS_W-1:0]  delay_ticks;
	} in_beat_t;

	typedef struct packed {
		logic [TASK_W-1:0] current_task;
		logic              switch_request;
		logic              none_ready;
		logic [MAP_W-1:0]  ready_map;
	} out_beat_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic walk;
		logic sched;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  ticks_nz;
		logic  walk_done;
		logic  out_free;
	} dp_status_t;

endpackage

// ===== src/pts_ctrl.sv =====
// control state machine of the priority task scheduler
module pts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output pts_pkg::dp_cmd_t    cmd,
	input  pts_pkg::dp_status_t status
);
	import pts_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_APPLY = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_SCHED = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				case (status.mode)
					MODE_TICK:  state_d = ST_WALK;
					MODE_READY: state_d = ST_DONE;
					MODE_DELAY: state_d = status.ticks_nz ? ST_SCHED : ST_DONE;
					MODE_SCHED: state_d = ST_SCHED;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_done) begin
					state_d = ST_SCHED;
				end
			end
			ST_SCHED: begin
				cmd.sched = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/pts_dp.sv =====
// datapath of the priority task scheduler: delay memory, ready map, search, result register
module pts_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pts_pkg::STEP_W-1:0] cfg_wdata,
	input  pts_pkg::in_beat_t         in_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output pts_pkg::out_beat_t        out_data,
	input  pts_pkg::dp_cmd_t          cmd,
	output pts_pkg::dp_status_t       status
);
	import pts_pkg::*;

	logic [STEP_W-1:0]     step_q;
	in_beat_t              item_q;
	logic [NUM_TASKS-1:0]  ready_q;
	logic [NUM_TASKS-1:0]  vld_q;
	logic [TASK_W-1:0]     run_q;
	logic [DELAY_BITS-1:0] mem [NUM_TASKS];
	logic [CNT_W-1:0]      cnt_q;
	logic                  rd_live_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  rd_vld_s1;
	logic [DELAY_BITS-1:0] rd_data_s1;
	logic                  sw_q;
	logic                  empty_q;
	logic                  out_valid_q;
	out_beat_t             out_q;

	logic                  slot_ok;
	logic [IDX_W-1:0]      slot_idx;
	logic [IDX_W-1:0]      run_idx;
	logic                  ticks_nz;
	logic                  do_ready;
	logic                  do_delay;
	logic                  walk_issue;
	logic                  walk_upd;
	logic [CMP_W-1:0]      d_ext;
	logic [CMP_W-1:0]      s_ext;
	logic [CMP_W-1:0]      nd_ext;
	logic                  expire;
	logic                  found;
	logic [IDX_W-1:0]      pick;
	logic [TASK_W-1:0]     pick_task;

	assign slot_ok    = {1'b0, item_q.task_index} < (TASK_W + 1)'(NUM_TASKS);
	assign slot_idx   = item_q.task_index[IDX_W-1:0];
	assign run_idx    = run_q[IDX_W-1:0];
	assign ticks_nz   = (item_q.delay_ticks != '0);
	assign do_ready   = cmd.apply && (item_q.mode == MODE_READY) && slot_ok;
	assign do_delay   = cmd.apply && (item_q.mode == MODE_DELAY) && ticks_nz;
	assign walk_issue = cmd.walk && (cnt_q < CNT_W'(NUM_TASKS));

	// saturating countdown of the entry read in the previous cycle
	assign walk_upd = rd_live_s1 && rd_vld_s1 && (rd_data_s1 != '0);
	assign d_ext    = CMP_W'(rd_data_s1);
	assign s_ext    = CMP_W'(step_q);
	assign nd_ext   = (d_ext > s_ext) ? (d_ext - s_ext) : '0;
	assign expire   = walk_upd && (nd_ext == '0);

	// lowest ready slot wins
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = NUM_TASKS - 1; i >= 0; i--) begin
			if (ready_q[i]) begin
				found = 1'b1;
				pick  = IDX_W'(i);
			end
		end
	end
	assign pick_task = TASK_W'(pick);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(STEP_RESET);
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	// delay memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (walk_upd) begin
			mem[rd_idx_s1] <= DELAY_BITS'(nd_ext);
		end else if (do_delay) begin
			mem[run_idx] <= DELAY_BITS'(item_q.delay_ticks);
		end
		if (walk_issue) begin
			rd_data_s1 <= mem[cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		rd_vld_s1 <= vld_q[cnt_q[IDX_W-1:0]];
	end

	// an entry never written since reset or since make ready reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (do_ready) begin
			vld_q[slot_idx] <= 1'b0;
		end else if (do_delay) begin
			vld_q[run_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
		end else begin
			if (do_ready) begin
				ready_q[slot_idx] <= 1'b1;
			end
			if (do_delay) begin
				ready_q[run_idx] <= 1'b0;
			end
			if (expire) begin
				ready_q[rd_idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			sw_q       <= 1'b0;
			empty_q    <= 1'b0;
			cnt_q      <= '0;
			rd_live_s1 <= 1'b0;
		end else begin
			rd_live_s1 <= walk_issue;
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (walk_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.capture) begin
				sw_q    <= 1'b0;
				empty_q <= 1'b0;
			end else if (cmd.sched) begin
				sw_q    <= found && (pick_task != run_q);
				empty_q <= !found;
				if (found) begin
					run_q <= pick_task;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.current_task   <= run_q;
			out_q.switch_request <= sw_q;
			out_q.none_ready     <= empty_q;
			out_q.ready_map      <= MAP_W'(ready_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.mode      = item_q.mode;
	assign status.ticks_nz  = ticks_nz;
	assign status.walk_done = (cnt_q == CNT_W'(NUM_TASKS));
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

// ===== src/priority_task_scheduler.sv =====
// top level of the priority task scheduler
// usage:
// - input channel in_valid / in_stall / in_data carries one beat per item: mode,
//   task_index, delay_ticks; output channel out_valid / out_stall / out_data
//   returns exactly one result beat per input beat, in order
// - cfg_we / cfg_wdata writes tick_step; write only while the block is idle
// - steps per item: make ready and a zero delay apply, then deliver; schedule
//   and a nonzero delay also search before delivering; a tick sweeps, then searches
// - a tick sweeps the delay memory one slot per cycle through its single read
//   port and single write port, then runs the priority search
// - one item at a time: the next input beat is taken in the cycle after the
//   result is loaded
// - the result sits in an output register; a new item may be accepted while it
//   waits, and the block holds its next result until the receiver takes the old
// - while out_stall is high the result beat holds steady
// - reset: ready map and running task clear, tick_step goes to 1, every delay
//   reads as zero at once through per-slot valid bits, no clearing pass
`include "priority_task_scheduler_macros.svh"

module priority_task_scheduler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pts_pkg::STEP_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  pts_pkg::in_beat_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output pts_pkg::out_beat_t         out_data
);
	import pts_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: idle, apply the item, sweep delays, search, deliver
	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// datapath: state, delay memory, priority search, result register
	pts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

	// an accepted beat always keeps the block busy for the next cycle
	`PTS_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && !in_stall) |=> in_stall, "input accepted twice in a row")

	// a switch needs a ready task, so both flags never show together
	`PTS_NEVER(a_flags_exclusive, clk, arst_n, out_valid && out_data.switch_request && out_data.none_ready, "switch and none_ready together")

	// none_ready only with an empty ready map
	`PTS_ASSERT(a_empty_map, clk, arst_n, (out_valid && out_data.none_ready) |-> (out_data.ready_map == '0), "none_ready with ready tasks")

endmodule
